// File: sv/rtc_pkg.sv
// Shared types, constants and helpers for the real-time clock calendar.
package rtc_pkg;

  // Default width of the year counter.
  localparam int unsigned YearBitsDef = 16;

  // Widths of the stream payloads (fields packed from bit 0, padded to whole bytes).
  localparam int unsigned LoadYearW = 16;
  localparam int unsigned OutYearW  = 16;
  localparam int unsigned STdataW   = 48;
  localparam int unsigned MTdataW   = 48;
  localparam int unsigned CmdW      = 2;

  // APB register map.
  localparam int unsigned PaddrW = 2;
  localparam logic [PaddrW-1:0] AddrDateEnable = 2'd0;

  // Command codes.
  localparam logic [CmdW-1:0] CmdTick = 2'd0;
  localparam logic [CmdW-1:0] CmdLoad = 2'd1;
  localparam logic [CmdW-1:0] CmdPoll = 2'd2;

  // Counter limits.
  localparam logic [5:0] SecLast    = 6'd59;
  localparam logic [5:0] MinLast    = 6'd59;
  localparam logic [4:0] HourLast   = 5'd23;
  localparam logic [2:0] WdayLast   = 3'd6;
  localparam logic [4:0] DayFirst   = 5'd1;
  localparam logic [3:0] MonthFirst = 4'd1;
  localparam logic [3:0] MonthLast  = 4'd12;
  localparam logic [3:0] MonthFeb   = 4'd2;

  // Month lengths.
  localparam logic [4:0] LenLong  = 5'd31;
  localparam logic [4:0] LenShort = 5'd30;
  localparam logic [4:0] LenLeap  = 5'd29;
  localparam logic [4:0] LenFeb   = 5'd28;
  localparam logic [4:0] LenNone  = 5'd0;

  // Time of day and date, without the year.
  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] min;
    logic [5:0] sec;
  } cal_t;

  // Length of a month; zero for a month code that is not a real month.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MonthFeb) begin
      len = leap ? LenLeap : LenFeb;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = LenShort;
    end else if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = LenLong;
    end else begin
      len = LenNone;
    end
    return len;
  endfunction

endpackage

// File: sv/rtc_calendar_counter.sv
// Top level of the real-time clock calendar with stream ports and APB configuration.
//
// The block takes one command per transfer on the slave stream: a one-second tick,
// a load of the whole time and date, or a poll of the update flag (command in tuser).
// Every command returns exactly one transfer on the master stream carrying the time
// and date as they stand after the command, plus the update flag on a poll. A new
// command is accepted in every clock cycle while the master side keeps up; a command
// waits first in the input register and its result then in the result register,
// and the full calendar update is done by the logic between those two registers. The
// input register frees up whenever the result register is empty or being read, so while
// a result waits on the master side one more command can still enter and wait in the
// input register; only after that does s_axis_tready drop until the result is taken.
// The date_enable register (APB offset 0) turns on the weekday, day, month and year
// update at midnight; it should be written only while no command is in flight.
// The year counter is YEAR_BITS wide and wraps at that width; the master stream
// carries its low 16 bits.
module rtc_calendar_counter #(
  parameter int unsigned YEAR_BITS = rtc_pkg::YearBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata, from bit 0: load_second[5:0], load_minute[11:6], load_hour[16:12],
  // load_weekday[19:17], load_day[24:20], load_month[28:25], load_year[44:29], zero pad.
  input  logic [rtc_pkg::STdataW-1:0]  s_axis_tdata,
  // tuser, from bit 0: command[1:0].
  input  logic [rtc_pkg::CmdW-1:0]     s_axis_tuser,
  // Master stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata, from bit 0: second[5:0], minute[11:6], hour[16:12], weekday[19:17],
  // day[24:20], month[28:25], year[44:29], updated[45], zero pad.
  output logic [rtc_pkg::MTdataW-1:0]  m_axis_tdata,
  // APB configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic                          date_enable;

  // Input register.
  logic                          in_valid_q, in_valid_d;
  logic [rtc_pkg::CmdW-1:0]      cmd_q, cmd_d;
  rtc_pkg::cal_t                 load_cal_q, load_cal_d;
  logic [rtc_pkg::LoadYearW-1:0] load_year_q, load_year_d;

  // Clock and calendar state.
  rtc_pkg::cal_t                 cal_q, cal_d;
  logic [YEAR_BITS-1:0]          year_q, year_d;
  logic                          pending_q, pending_d;
  logic                          updated;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [rtc_pkg::MTdataW-1:0]   out_data_q, out_data_d;

  logic                          in_fire;
  logic                          advance;
  logic [YEAR_BITS+rtc_pkg::OutYearW-1:0] year_ext;

  rtc_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .date_enable_o (date_enable)
  );

  // The held command moves on when the result register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    cmd_d       = cmd_q;
    load_cal_d  = load_cal_q;
    load_year_d = load_year_q;
    if (in_fire) begin
      in_valid_d       = 1'b1;
      cmd_d            = s_axis_tuser;
      load_cal_d.sec   = s_axis_tdata[5:0];
      load_cal_d.min   = s_axis_tdata[11:6];
      load_cal_d.hour  = s_axis_tdata[16:12];
      load_cal_d.wday  = s_axis_tdata[19:17];
      load_cal_d.day   = s_axis_tdata[24:20];
      load_cal_d.month = s_axis_tdata[28:25];
      load_year_d      = s_axis_tdata[44:29];
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  rtc_step #(
    .YEAR_BITS (YEAR_BITS)
  ) u_step (
    .cmd_i         (cmd_q),
    .load_cal_i    (load_cal_q),
    .load_year_i   (load_year_q),
    .date_enable_i (date_enable),
    .cal_i         (cal_q),
    .year_i        (year_q),
    .pending_i     (pending_q),
    .cal_o         (cal_d),
    .year_o        (year_d),
    .pending_o     (pending_d),
    .updated_o     (updated)
  );

  // The year leaves on 16 bits whatever the counter width is.
  assign year_ext = {{rtc_pkg::OutYearW{1'b0}}, year_d};

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = {2'b00, updated, year_ext[rtc_pkg::OutYearW-1:0], cal_d.month, cal_d.day,
                     cal_d.wday, cal_d.hour, cal_d.min, cal_d.sec};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      cal_q.sec       <= 6'd0;
      cal_q.min       <= 6'd0;
      cal_q.hour      <= 5'd0;
      cal_q.wday      <= 3'd0;
      cal_q.day       <= rtc_pkg::DayFirst;
      cal_q.month     <= rtc_pkg::MonthFirst;
      year_q          <= '0;
      pending_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        cal_q     <= cal_d;
        year_q    <= year_d;
        pending_q <= pending_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    load_cal_q  <= load_cal_d;
    load_year_q <= load_year_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/rtc_apb_regs.sv
// APB configuration register block holding the date enable bit.
module rtc_apb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rtc_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic                      date_enable_o
);

  logic date_enable_q;
  logic date_enable_d;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr == rtc_pkg::AddrDateEnable);

  always_comb begin
    date_enable_d = date_enable_q;
    if (psel && penable && pwrite && pready && hit) begin
      date_enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_enable_q <= 1'b0;
    end else begin
      date_enable_q <= date_enable_d;
    end
  end

  assign prdata        = hit ? {31'b0, date_enable_q} : 32'b0;
  assign date_enable_o = date_enable_q;

endmodule

// File: sv/rtc_step.sv
// Next-state logic of the clock calendar for one command.
module rtc_step #(
  parameter int unsigned YEAR_BITS = rtc_pkg::YearBitsDef
) (
  input  logic [rtc_pkg::CmdW-1:0]      cmd_i,
  input  rtc_pkg::cal_t                 load_cal_i,
  input  logic [rtc_pkg::LoadYearW-1:0] load_year_i,
  input  logic                          date_enable_i,
  input  rtc_pkg::cal_t                 cal_i,
  input  logic [YEAR_BITS-1:0]          year_i,
  input  logic                          pending_i,
  output rtc_pkg::cal_t                 cal_o,
  output logic [YEAR_BITS-1:0]          year_o,
  output logic                          pending_o,
  output logic                          updated_o
);

  logic                                  sec_wrap;
  logic                                  min_wrap;
  logic                                  hour_wrap;
  logic                                  midnight;
  logic [4:0]                            len;
  rtc_pkg::cal_t                         tick_cal;
  logic [YEAR_BITS-1:0]                  tick_year;
  logic [3:0]                            month_mid;
  logic [YEAR_BITS+rtc_pkg::LoadYearW-1:0] load_year_ext;

  assign sec_wrap  = (cal_i.sec >= rtc_pkg::SecLast);
  assign min_wrap  = (cal_i.min >= rtc_pkg::MinLast);
  assign hour_wrap = (cal_i.hour >= rtc_pkg::HourLast);
  assign midnight  = sec_wrap && min_wrap && hour_wrap && date_enable_i;
  assign len       = rtc_pkg::month_len(cal_i.month, (year_i[1:0] == 2'b00));

  assign load_year_ext = {{YEAR_BITS{1'b0}}, load_year_i};

  always_comb begin
    tick_cal  = cal_i;
    tick_year = year_i;
    month_mid = cal_i.month;

    // Seconds, minutes and hours ripple their carries.
    tick_cal.sec = sec_wrap ? 6'd0 : cal_i.sec + 6'd1;
    if (sec_wrap) begin
      tick_cal.min = min_wrap ? 6'd0 : cal_i.min + 6'd1;
      if (min_wrap) begin
        tick_cal.hour = hour_wrap ? 5'd0 : cal_i.hour + 5'd1;
      end
    end

    // The calendar part only moves at midnight with the date enabled.
    if (midnight) begin
      tick_cal.wday = (cal_i.wday >= rtc_pkg::WdayLast) ? 3'd0 : cal_i.wday + 3'd1;
      if (len == rtc_pkg::LenNone) begin
        // A month code that is not a real month never rolls the day over.
        tick_cal.day = cal_i.day + 5'd1;
      end else if (cal_i.day >= len) begin
        tick_cal.day = rtc_pkg::DayFirst;
        month_mid    = cal_i.month + 4'd1;
      end else begin
        tick_cal.day = cal_i.day + 5'd1;
      end
      tick_cal.month = month_mid;
      if (month_mid > rtc_pkg::MonthLast) begin
        tick_cal.month = rtc_pkg::MonthFirst;
        tick_year      = year_i + YEAR_BITS'(1);
      end
    end
  end

  always_comb begin
    cal_o     = cal_i;
    year_o    = year_i;
    pending_o = pending_i;
    updated_o = 1'b0;
    case (cmd_i)
      rtc_pkg::CmdTick: begin
        cal_o     = tick_cal;
        year_o    = tick_year;
        pending_o = 1'b1;
      end
      rtc_pkg::CmdLoad: begin
        cal_o  = load_cal_i;
        year_o = load_year_ext[YEAR_BITS-1:0];
      end
      rtc_pkg::CmdPoll: begin
        updated_o = pending_i;
        pending_o = 1'b0;
      end
      default: begin
        cal_o = cal_i;
      end
    endcase
  end

endmodule

// File: sim/rtc_checker.sv
// Checker for the calendar counter: predicts every result and compares it on the master stream.
module rtc_checker
  import rtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [STdataW-1:0] s_axis_tdata,
  input  logic [CmdW-1:0]    s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [MTdataW-1:0] m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 errors_o,
  output int                 in_flight_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Same bit order as the low part of both stream payloads.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
  } clock_face_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic        updated;
    clock_face_t face;
  } readout_t;

  clock_face_t face;
  logic        tick_seen;
  logic        date_on;
  readout_t    expected_readouts[$];
  readout_t    prediction;
  readout_t    oldest;
  readout_t    got;
  int          misses;
  int          delta;

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic [15:0] year);
    logic [4:0] days;
    case (month)
      4'd2:                                  days = (year[1:0] == 2'b00) ? LenLeap : LenFeb;
      4'd4, 4'd6, 4'd9, 4'd11:               days = LenShort;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = LenLong;
      default:                               days = LenNone;
    endcase
    return days;
  endfunction

  // One second forward; the calendar part only moves at midnight with dates on.
  function automatic clock_face_t tick_clock(input clock_face_t t, input logic dates);
    clock_face_t n;
    logic [4:0]  days;
    n = t;
    if (t.sec < SecLast) begin
      n.sec = t.sec + 6'd1;
    end else begin
      n.sec = '0;
      if (t.min < MinLast) begin
        n.min = t.min + 6'd1;
      end else begin
        n.min = '0;
        if (t.hour < HourLast) begin
          n.hour = t.hour + 5'd1;
        end else begin
          n.hour = '0;
          if (dates) begin
            n.wday = (t.wday >= WdayLast) ? 3'd0 : t.wday + 3'd1;
            days = days_in_month(t.month, t.year);
            if (days == LenNone) begin
              n.day = t.day + 5'd1;
            end else if (t.day >= days) begin
              n.day   = DayFirst;
              n.month = t.month + 4'd1;
            end else begin
              n.day = t.day + 5'd1;
            end
            if (n.month > MonthLast) begin
              n.month = MonthFirst;
              n.year  = t.year + 16'd1;
            end
          end
        end
      end
    end
    return n;
  endfunction

  function automatic int field_miss(input string name, input int want, input int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face       = '0;
      face.day   = DayFirst;
      face.month = MonthFirst;
      tick_seen  = 1'b0;
      date_on    = 1'b0;
      expected_readouts.delete();
      in_flight_o <= 0;
    end else begin
      misses = 0;
      delta  = 0;

      if (psel && penable && pready && paddr == AddrDateEnable) begin
        if (pwrite) begin
          date_on = pwdata[0];
        end else begin
          misses += field_miss("date_enable", int'({31'd0, date_on}), int'(prdata));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        prediction = '0;
        case (s_axis_tuser)
          CmdTick: begin
            face      = tick_clock(face, date_on);
            tick_seen = 1'b1;
          end
          CmdLoad: face = clock_face_t'(s_axis_tdata[$bits(clock_face_t)-1:0]);
          CmdPoll: begin
            prediction.updated = tick_seen;
            tick_seen          = 1'b0;
          end
          default: ;
        endcase
        prediction.face = face;
        expected_readouts.push_back(prediction);
        delta++;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = readout_t'(m_axis_tdata);
        if (expected_readouts.size() == 0) begin
          $error("result transfer with no command waiting: %h", m_axis_tdata);
          misses++;
        end else begin
          oldest = expected_readouts.pop_front();
          delta--;
          misses += field_miss("second",  int'(oldest.face.sec),   int'(got.face.sec));
          misses += field_miss("minute",  int'(oldest.face.min),   int'(got.face.min));
          misses += field_miss("hour",    int'(oldest.face.hour),  int'(got.face.hour));
          misses += field_miss("weekday", int'(oldest.face.wday),  int'(got.face.wday));
          misses += field_miss("day",     int'(oldest.face.day),   int'(got.face.day));
          misses += field_miss("month",   int'(oldest.face.month), int'(got.face.month));
          misses += field_miss("year",    int'(oldest.face.year),  int'(got.face.year));
          misses += field_miss("updated", int'(oldest.updated),    int'(got.updated));
          misses += field_miss("pad",     int'(oldest.pad),        int'(got.pad));
        end
      end

      errors_o    <= errors_o + misses;
      in_flight_o <= in_flight_o + delta;
    end
  end

endmodule

// File: sim/tb_top.sv
// Top of the calendar counter testbench: clock, reset, stimulus and the final verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtc_pkg::*;

  // The command code that the block has no use for; it must leave the state alone.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam int IdlePercent  = 14;
  localparam int PhaseCount   = 4;
  localparam int PhaseItems   = 200;
  localparam int CalmItems    = 120;
  // A result leaves through the input and result registers and the block takes a command
  // in every cycle while the result side keeps up, so an idle run that reaches StallLimit
  // can only mean that it is stuck.
  localparam int StallLimit   = 1000;
  localparam int DrainCycles  = 8;

  // Every load field set to ones: used as payload noise on commands that ignore it.
  localparam logic [STdataW-1:0] LoadBitsSet = {3'b000, {45{1'b1}}};

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [STdataW-1:0] s_axis_tdata;
  logic [CmdW-1:0]    s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MTdataW-1:0] m_axis_tdata;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int   error_count;
  int   in_flight;
  int   idle_run = 0;
  // While calm is set, neither the command side nor the result side ever pauses.
  logic calm = 1'b0;

  rtc_calendar_counter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The checker sees every channel, keeps its own calendar and reports back how many
  // mismatches it found and how many results are still owed.
  rtc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors_o      (error_count),
    .in_flight_o   (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The result side pulls most of the time and holds off in about one cycle out of seven.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // Count cycles in which nothing moves on any channel; APB activity counts as motion.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    while (idle_run < StallLimit) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  // Packs a load payload in tdata order, seconds in the lowest bits.
  function automatic logic [STdataW-1:0] clock_word(
    input logic [5:0] sec, input logic [5:0] min, input logic [4:0] hour,
    input logic [2:0] wday, input logic [4:0] day, input logic [3:0] month,
    input logic [15:0] year);
    return {3'b000, year, month, day, wday, hour, min, sec};
  endfunction

  // A load placed a few seconds before a carry, often right before midnight and at
  // the end of a month, so that the ticks that follow walk through the rollovers.
  function automatic logic [STdataW-1:0] near_rollover_word();
    logic [3:0] month;
    month = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
    return clock_word(6'($urandom_range(59, 50)),
                      ($urandom_range(1) == 1) ? MinLast : 6'($urandom_range(59)),
                      ($urandom_range(1) == 1) ? HourLast : 5'($urandom_range(23)),
                      3'($urandom_range(6)), 5'($urandom_range(31, 26)), month,
                      16'($urandom));
  endfunction

  function automatic logic [STdataW-1:0] noise_word();
    return {3'b000, 13'($urandom), $urandom()};
  endfunction

  // Offers one command and returns right after the edge at which the transfer happens.
  // tvalid gets exactly one assignment per step, whether it pauses or goes on.
  task automatic send(input logic [CmdW-1:0] cmd, input logic [STdataW-1:0] word);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= noise_word();
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly ticks, with loads that set up rollovers, polls and a few unused codes.
  task automatic send_random_command();
    int pick;
    pick = $urandom_range(99);
    if (pick < 58) begin
      send(CmdTick, noise_word());
    end else if (pick < 78) begin
      send(CmdLoad, ($urandom_range(9) < 7) ? near_rollover_word() : noise_word());
    end else if (pick < 94) begin
      send(CmdPoll, noise_word());
    end else begin
      send(CmdUnused, noise_word());
    end
  endtask

  // Stops offering commands and waits until every result owed has come back. Every
  // command makes a result, so an empty count means the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
  endtask

  // One APB transfer: a setup phase, then access until pready is seen high.
  task automatic apb_transfer(input logic write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= AddrDateEnable;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes date_enable and reads it back; the checker compares the read data.
  task automatic set_date_enable(input logic enable);
    apb_transfer(1'b1, {31'd0, enable});
    apb_transfer(1'b0, 32'd0);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CmdTick;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= AddrDateEnable;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Update flag: clear after reset, set by a tick, cleared by the first poll. The
    // unused code must change nothing even with every payload bit set.
    send(CmdPoll, '0);
    send(CmdTick, LoadBitsSet);
    send(CmdPoll, '0);
    send(CmdPoll, LoadBitsSet);
    send(CmdUnused, LoadBitsSet);

    // With dates off, midnight wraps the time of day but leaves the date alone.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, WdayLast, LenLong, MonthLast, 16'd0));
    send(CmdTick, '0);
    drain();
    set_date_enable(1'b1);

    // New Year's Eve at the top of the year counter: everything carries and the year wraps.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, WdayLast, LenLong, MonthLast,
                             16'hFFFF));
    send(CmdTick, '0);
    // February in a leap year goes to the 29th, then to March.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, 3'd2, LenFeb, MonthFeb, 16'd2024));
    send(CmdTick, '0);
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, 3'd3, LenLeap, MonthFeb, 16'd2024));
    send(CmdTick, '0);
    // February outside a leap year ends on the 28th.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, 3'd1, LenFeb, MonthFeb, 16'd2023));
    send(CmdTick, '0);
    // A thirty-day month.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, 3'd4, LenShort, 4'd4, 16'd7));
    send(CmdTick, '0);
    // Month zero is not a real month: the day counts on and wraps at 32, no month carry.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, 3'd5, 5'd31, 4'd0, 16'd100));
    send(CmdTick, '0);
    // A month above twelve turns into January of the next year at midnight.
    send(CmdLoad, clock_word(SecLast, MinLast, HourLast, 3'd0, 5'd5, 4'd15, 16'd100));
    send(CmdTick, '0);
    // Every loaded field at its all-ones value: each counter is past its limit and wraps.
    send(CmdLoad, LoadBitsSet);
    send(CmdTick, '0);
    // All zeros, including a day and month of zero, then a poll after all those ticks.
    send(CmdLoad, '0);
    send(CmdPoll, '0);

    // Random part in phases; date_enable changes only between phases, with the block
    // drained. The third phase opens with a stretch where nobody pauses.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      set_date_enable(phase != 1);
      for (int item = 0; item < PhaseItems; item++) begin
        calm <= (phase == 2) && (item < CalmItems);
        send_random_command();
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
